>>> src/sat_pkg.sv
// Shared types and constants for the summed-area table box-sum block.
package sat_pkg;

	// Default sizing of the table.
	localparam int MAX_ROWS_DEF  = 64;
	localparam int MAX_COLS_DEF  = 64;
	localparam int SUM_WIDTH_DEF = 48;

	// Fixed field widths.
	localparam int IDX_W     = 6;
	localparam int DIM_W     = 7;
	localparam int CELL_W    = 32;
	localparam int OUT_W     = 48;
	localparam int CFG_IDX_W = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd1;

	// Input item operations.
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Status codes.
	localparam logic ST_OK      = 1'b0;
	localparam logic ST_OUTSIDE = 1'b1;

	// Command to the table memory.
	typedef struct packed {
		logic en;
		logic we;
	} ram_cmd_t;

endpackage

>>> src/sat_ram.sv
// Single-port table memory with registered read data.
module sat_ram #(
	parameter int DEPTH = sat_pkg::MAX_ROWS_DEF * sat_pkg::MAX_COLS_DEF,
	parameter int AW    = 12,
	parameter int DW    = sat_pkg::SUM_WIDTH_DEF
) (
	input  logic             clk,
	input  sat_pkg::ram_cmd_t cmd,
	input  logic [AW-1:0]    addr,
	input  logic [DW-1:0]    wdata,
	output logic [DW-1:0]    rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (cmd.en) begin
			if (cmd.we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

>>> src/summed_area_table_box_sum.sv
// Top level: summed-area table builder with four-corner box-sum queries.
//
//  Channel | Handshake             | Payload
//  --------+-----------------------+-------------------------------------------------
//  in      | in_valid / in_ready   | opcode, first_cell, cell_value, left_col,
//          |                       | top_row, right_col, bottom_row
//  out     | out_valid / out_ready | box_sum, status
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data (grid_rows, grid_cols)
//
// A load reads the left neighbor from the single-port table memory (S_LD_RD),
// then writes (S_LD_WR); in column 0 it only writes. An ignored load stays in
// S_IDLE. A query reads four corners through the same port (S_QRD), waits for
// the last read data (S_QTAIL) and loads the output register (S_PUSH), or goes
// straight to S_PUSH with a corner outside the grid. Reset clears the cursor,
// running sum and control state and sets grid sizes to 1, but not the datapath
// registers or table. A stalled output holds only a finished query in S_PUSH.
module summed_area_table_box_sum #(
	parameter int MAX_ROWS  = sat_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS  = sat_pkg::MAX_COLS_DEF,
	parameter int SUM_WIDTH = sat_pkg::SUM_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                opcode,
	input  logic                                first_cell,
	input  logic signed [sat_pkg::CELL_W-1:0]   cell_value,
	input  logic        [sat_pkg::IDX_W-1:0]    left_col,
	input  logic        [sat_pkg::IDX_W-1:0]    top_row,
	input  logic        [sat_pkg::IDX_W-1:0]    right_col,
	input  logic        [sat_pkg::IDX_W-1:0]    bottom_row,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [sat_pkg::OUT_W-1:0]    box_sum,
	output logic                                status,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic        [sat_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic        [sat_pkg::DIM_W-1:0]    cfg_data
);

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IW    = sat_pkg::IDX_W;
	localparam int DW    = sat_pkg::DIM_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LD_RD,
		S_LD_WR,
		S_QRD,
		S_QTAIL,
		S_PUSH
	} state_t;

	function automatic logic [AW-1:0] cell_addr(logic [DW-1:0] col, logic [IW-1:0] row);
		return AW'(int'(col) * MAX_ROWS + int'(row));
	endfunction

	state_t              state_q;
	logic [DW-1:0]       grid_rows_q, grid_cols_q;
	logic [DW-1:0]       rows_c, cols_c;

	// Load cursor.
	logic [IW-1:0]        load_row_q;
	logic [DW-1:0]        load_col_q;
	logic                 load_done_q;
	logic [SUM_WIDTH-1:0] col_sum_q;

	// Load work registers.
	logic [AW-1:0]        ld_addr_q, ld_prev_addr_q;
	logic [SUM_WIDTH-1:0] ld_sum_q;
	logic                 ld_prev_q;

	// Query work registers.
	logic [AW-1:0]        q_addr_q [4];
	logic [3:0]           q_use_q;
	logic [1:0]           q_k_q;
	logic                 rd_vld_s1;
	logic [1:0]           rd_k_s1;
	logic [SUM_WIDTH-1:0] acc_q;
	logic                 res_status_q;

	logic                 out_valid_q;
	logic [sat_pkg::OUT_W-1:0] box_sum_q;
	logic                 status_q;

	// Memory port.
	sat_pkg::ram_cmd_t    ram_cmd;
	logic [AW-1:0]        ram_addr;
	logic [SUM_WIDTH-1:0] ram_wdata, ram_rdata;

	logic accept;

	// Load decode.
	logic [IW-1:0]        r0, r1;
	logic [DW-1:0]        c0, c1, c1_inc, r2;
	logic                 d0, wrap, skip, col_end, last_col;
	logic [SUM_WIDTH-1:0] s0, s1, s2;
	logic [IW-1:0]        nxt_row;
	logic [DW-1:0]        nxt_col;
	logic                 nxt_done;
	logic [SUM_WIDTH-1:0] nxt_sum;

	// Query decode.
	logic                 outside, use_l, use_t;
	logic [DW-1:0]        qc_r, qc_l;
	logic [IW-1:0]        qr_b, qr_t;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign box_sum   = box_sum_q;
	assign status    = status_q;

	// Out-of-range register values act as the nearest legal size.
	always_comb begin
		if (grid_rows_q == '0) begin
			rows_c = DW'(1);
		end else if (int'(grid_rows_q) > MAX_ROWS) begin
			rows_c = DW'(MAX_ROWS);
		end else begin
			rows_c = grid_rows_q;
		end
		if (grid_cols_q == '0) begin
			cols_c = DW'(1);
		end else if (int'(grid_cols_q) > MAX_COLS) begin
			cols_c = DW'(MAX_COLS);
		end else begin
			cols_c = grid_cols_q;
		end
	end

	// Next load cursor, worked out at the accepting edge.
	always_comb begin
		r0 = first_cell ? '0 : load_row_q;
		c0 = first_cell ? '0 : load_col_q;
		d0 = first_cell ? 1'b0 : load_done_q;
		s0 = first_cell ? '0 : col_sum_q;

		// A row count that shrank below the cursor moves it to the next column.
		wrap = ({1'b0, r0} >= rows_c);
		r1   = wrap ? '0 : r0;
		c1   = wrap ? c0 + DW'(1) : c0;
		s1   = wrap ? '0 : s0;
		skip = d0 || (c1 >= cols_c);

		s2       = s1 + SUM_WIDTH'(cell_value);
		r2       = {1'b0, r1} + DW'(1);
		c1_inc   = c1 + DW'(1);
		col_end  = (r2 >= rows_c);
		last_col = (c1_inc >= cols_c);

		if (d0) begin
			nxt_row  = r0;
			nxt_col  = c0;
			nxt_done = d0;
			nxt_sum  = s0;
		end else if (skip) begin
			nxt_row  = r1;
			nxt_col  = c1;
			nxt_done = 1'b0;
			nxt_sum  = s1;
		end else if (col_end) begin
			nxt_row  = '0;
			nxt_sum  = '0;
			nxt_done = last_col;
			nxt_col  = last_col ? {1'b0, c1[IW-1:0]} : {1'b0, c1_inc[IW-1:0]};
		end else begin
			nxt_row  = r2[IW-1:0];
			nxt_col  = {1'b0, c1[IW-1:0]};
			nxt_done = 1'b0;
			nxt_sum  = s2;
		end
	end

	// Query decode. Unused corners point at a legal entry; their data is dropped.
	always_comb begin
		outside = ({1'b0, left_col} >= cols_c) || ({1'b0, right_col} >= cols_c) ||
			({1'b0, top_row} >= rows_c) || ({1'b0, bottom_row} >= rows_c);
		use_l = (left_col != '0);
		use_t = (top_row != '0);
		qc_r  = {1'b0, right_col};
		qc_l  = use_l ? {1'b0, left_col - IW'(1)} : qc_r;
		qr_b  = bottom_row;
		qr_t  = use_t ? top_row - IW'(1) : qr_b;
	end

	// Memory port selection.
	always_comb begin
		ram_cmd   = '0;
		ram_addr  = ld_addr_q;
		ram_wdata = ld_sum_q + (ld_prev_q ? ram_rdata : '0);
		unique case (state_q)
			S_LD_RD: begin
				ram_cmd.en = 1'b1;
				ram_addr   = ld_prev_addr_q;
			end
			S_LD_WR: begin
				ram_cmd.en = 1'b1;
				ram_cmd.we = 1'b1;
			end
			S_QRD: begin
				ram_cmd.en = 1'b1;
				ram_addr   = q_addr_q[q_k_q];
			end
			default: begin
				ram_cmd = '0;
			end
		endcase
	end

	sat_ram #(
		.DEPTH(DEPTH),
		.AW   (AW),
		.DW   (SUM_WIDTH)
	) u_ram (
		.clk  (clk),
		.cmd  (ram_cmd),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= DW'(1);
			grid_cols_q <= DW'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				sat_pkg::REG_GRID_ROWS: grid_rows_q <= cfg_data;
				sat_pkg::REG_GRID_COLS: grid_cols_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Control state, cursor and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			load_row_q   <= '0;
			load_col_q   <= '0;
			load_done_q  <= 1'b0;
			col_sum_q    <= '0;
			q_k_q        <= '0;
			rd_vld_s1    <= 1'b0;
			rd_k_s1      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == S_QRD);
			rd_k_s1   <= q_k_q;
			// A finished query refills the output register in the cycle it drains.
			if (state_q == S_PUSH && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (opcode == sat_pkg::OP_LOAD) begin
							load_row_q  <= nxt_row;
							load_col_q  <= nxt_col;
							load_done_q <= nxt_done;
							col_sum_q   <= nxt_sum;
							if (!skip) begin
								state_q <= (c1 != '0) ? S_LD_RD : S_LD_WR;
							end
						end else begin
							q_k_q   <= '0;
							state_q <= outside ? S_PUSH : S_QRD;
						end
					end
				end
				S_LD_RD: state_q <= S_LD_WR;
				S_LD_WR: state_q <= S_IDLE;
				S_QRD: begin
					q_k_q <= q_k_q + 2'd1;
					if (q_k_q == 2'd3) begin
						state_q <= S_QTAIL;
					end
				end
				S_QTAIL: state_q <= S_PUSH;
				S_PUSH: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			ld_addr_q      <= cell_addr(c1, r1);
			ld_prev_addr_q <= cell_addr(c1 - DW'(1), r1);
			ld_prev_q      <= (c1 != '0);
			ld_sum_q       <= s2;
			q_addr_q[0]    <= cell_addr(qc_r, qr_b);
			q_addr_q[1]    <= cell_addr(qc_l, qr_b);
			q_addr_q[2]    <= cell_addr(qc_r, qr_t);
			q_addr_q[3]    <= cell_addr(qc_l, qr_t);
			q_use_q        <= {use_l && use_t, use_t, use_l, 1'b1};
			acc_q          <= '0;
			res_status_q   <= outside ? sat_pkg::ST_OUTSIDE : sat_pkg::ST_OK;
		end else if (rd_vld_s1 && q_use_q[rd_k_s1]) begin
			// Corners: bottom-right and top-left add, the other two subtract.
			if (rd_k_s1 == 2'd0 || rd_k_s1 == 2'd3) begin
				acc_q <= acc_q + ram_rdata;
			end else begin
				acc_q <= acc_q - ram_rdata;
			end
		end
		if (state_q == S_PUSH && (!out_valid_q || out_ready)) begin
			box_sum_q <= sat_pkg::OUT_W'($signed(acc_q));
			status_q  <= res_status_q;
		end
	end

	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == sat_pkg::ST_OUTSIDE |-> box_sum == '0)
		else $error("outside-grid result carries a nonzero sum");

	a_result_from_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_PUSH))
		else $error("result appeared without a finished query");

	a_query_flow: assert property (@(posedge clk) disable iff (!arst_n)
		accept && opcode == sat_pkg::OP_QUERY |=> state_q == S_QRD || state_q == S_PUSH)
		else $error("accepted query did not start");

	a_read_tag: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_QRD |=> rd_vld_s1 && rd_k_s1 == $past(q_k_q))
		else $error("corner read lost its tag");

	a_write_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LD_RD |=> state_q == S_LD_WR && ld_prev_q)
		else $error("neighbor read not followed by its write");

endmodule
